[rtl/mhpq_pkg.sv]
package mhpq_pkg;

    // Key width and default depth
    localparam int KEY_W            = 32;
    localparam int DEFAULT_CAPACITY = 256;

    // Operation codes carried on i_mode
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Status codes reported with each result
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic rem;
        t_key key;
    } t_cmd;

endpackage

[rtl/min_heap_priority_queue_unit.sv]
// Priority queue of signed 32-bit keys: each beat on start either inserts
// i_key_in (i_mode low) or removes the smallest key held (i_mode high). Keys
// live in a row of CAPACITY cells kept in sorted order; an insert or remove
// updates every cell in the cycle of the accepting edge, and the result is
// registered from the head cell in the cycle after. One result beat follows each
// accepted beat, strobed by o_result_valid for exactly one cycle; the receiver
// cannot stall it, so capture it then. busy is high for the one cycle between
// acceptance and result, so a new beat is not accepted until the result is
// registered. Removing from an empty queue reports status 1 and inserting
// into a full queue status 2; neither changes the contents.
module min_heap_priority_queue_unit #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY,
    localparam int CntW    = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_mode,
    input  logic signed [mhpq_pkg::KEY_W-1:0] i_key_in,
    output logic                        o_result_valid,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_removed_key,
    output logic signed [mhpq_pkg::KEY_W-1:0] o_current_min,
    output logic [CntW-1:0]             o_entry_count,
    output logic                        o_heap_empty,
    output logic [1:0]                  o_status
);

    logic            accept;
    logic            full;
    logic            empty;
    mhpq_pkg::t_cmd  cmd;
    mhpq_pkg::t_key  head_key;
    logic            head_valid;

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic            r_pend;
    mhpq_pkg::t_key  r_removed;
    mhpq_pkg::t_key  n_removed;
    logic [1:0]      r_status;
    logic [1:0]      n_status;

    assign busy   = r_pend;
    assign accept = start && !busy;
    assign full   = (r_count == CntW'(CAPACITY));
    assign empty  = (r_count == '0);

    // Decode the beat into a row command and its status
    always_comb begin
        cmd.ins   = 1'b0;
        cmd.rem   = 1'b0;
        cmd.key   = i_key_in;
        n_count   = r_count;
        n_removed = '0;
        n_status  = mhpq_pkg::STATUS_OK;
        if (accept) begin
            if (i_mode == mhpq_pkg::MODE_INSERT) begin
                if (full) begin
                    n_status = mhpq_pkg::STATUS_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + CntW'(1);
                end
            end else begin
                if (empty) begin
                    n_status = mhpq_pkg::STATUS_EMPTY;
                end else begin
                    cmd.rem   = 1'b1;
                    n_count   = r_count - CntW'(1);
                    n_removed = head_key;
                end
            end
        end
    end

    mhpq_row #(
        .Capacity (CAPACITY)
    ) u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_head_key   (head_key),
        .o_head_valid (head_valid)
    );

    // Track fill count and the pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_pend         <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_count        <= n_count;
            r_pend         <= accept;
            o_result_valid <= r_pend;
        end
    end

    // Hold per-item side results until the row has settled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed <= n_removed;
            r_status  <= n_status;
        end
    end

    // Register the result beat from the updated head cell
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            o_removed_key <= r_removed;
            o_current_min <= head_valid ? head_key : '0;
            o_entry_count <= r_count;
            o_heap_empty  <= (r_count == '0);
            o_status      <= r_status;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(CAPACITY))
        else $error("fill count above capacity");

    a_head_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid == (r_count != '0))
        else $error("head cell occupancy disagrees with fill count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> o_result_valid)
        else $error("result beat missing after accepted item");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (i_mode == mhpq_pkg::MODE_INSERT) |=> r_count == $past(r_count))
        else $error("insert into full queue changed the count");
`endif

endmodule

[rtl/mhpq_cell.sv]
module mhpq_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mhpq_pkg::t_cmd   i_cmd,
    input  mhpq_pkg::t_key   i_left_key,
    input  logic             i_left_valid,
    input  logic             i_left_lt,
    input  mhpq_pkg::t_key   i_right_key,
    input  logic             i_right_valid,
    output mhpq_pkg::t_key   o_key,
    output logic             o_valid,
    output logic             o_lt
);

    mhpq_pkg::t_key r_key;
    logic           r_valid;
    mhpq_pkg::t_key n_key;
    logic           n_valid;

    // New key belongs at or before this slot: slot is empty or holds a larger key
    assign o_lt = !r_valid || (i_cmd.key < r_key);

    // Pick next contents: keep, take the new key, shift from left or from right
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_cmd.ins) begin
            if (o_lt && !i_left_lt) begin
                n_key   = i_cmd.key;
                n_valid = 1'b1;
            end else if (o_lt) begin
                n_key   = i_left_key;
                n_valid = i_left_valid;
            end
        end else if (i_cmd.rem) begin
            n_key   = i_right_key;
            n_valid = i_right_valid;
        end
    end

    // Hold key without reset, clear occupancy on reset
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

[rtl/mhpq_row.sv]
module mhpq_row #(
    parameter int Capacity = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mhpq_pkg::t_cmd i_cmd,
    output mhpq_pkg::t_key o_head_key,
    output logic           o_head_valid
);

    mhpq_pkg::t_key key_q   [Capacity];
    logic           valid_q [Capacity];
    logic           lt_q    [Capacity];

    // Build the sorted row, smallest key in slot zero
    for (genvar g = 0; g < Capacity; g++) begin : g_cell
        mhpq_pkg::t_key left_key;
        logic           left_valid;
        logic           left_lt;
        mhpq_pkg::t_key right_key;
        logic           right_valid;

        if (g == 0) begin : g_first
            assign left_key   = '0;
            assign left_valid = 1'b0;
            assign left_lt    = 1'b0;
        end else begin : g_inner_l
            assign left_key   = key_q[g-1];
            assign left_valid = valid_q[g-1];
            assign left_lt    = lt_q[g-1];
        end

        if (g == Capacity - 1) begin : g_last
            assign right_key   = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner_r
            assign right_key   = key_q[g+1];
            assign right_valid = valid_q[g+1];
        end

        mhpq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (i_cmd),
            .i_left_key    (left_key),
            .i_left_valid  (left_valid),
            .i_left_lt     (left_lt),
            .i_right_key   (right_key),
            .i_right_valid (right_valid),
            .o_key         (key_q[g]),
            .o_valid       (valid_q[g]),
            .o_lt          (lt_q[g])
        );
    end

    assign o_head_key   = key_q[0];
    assign o_head_valid = valid_q[0];

endmodule
